FILE: hdl/sorted_static_list_insert_assert.svh
// Assertion macros for the sorted static list blocks.
// Expects clk and rst_n in the scope that uses them.
`ifndef SORTED_STATIC_LIST_INSERT_ASSERT_SVH
`define SORTED_STATIC_LIST_INSERT_ASSERT_SVH

// same-cycle implication
`define SSLI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ssli_pkg.sv
// Shared types and constants for the sorted static list.
// No dependencies.
package ssli_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int GROUP_SIZE   = 16;

    typedef enum logic [1:0] {
        CMD_APPEND  = 2'd0,
        CMD_HEAD    = 2'd1,
        CMD_ORDERED = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [31:0] key;
        logic [63:0]        payload;
        logic [6:0]         position;
    } in_item_t;

    typedef struct packed {
        logic               accepted;
        logic [7:0]         count;
        logic               full_res;
        logic               empty_res;
        logic signed [31:0] read_key;
        logic [63:0]        read_payload;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [63:0]        payload;
    } entry_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic     eval;
        logic     write;
        in_item_t item;
    } cell_ctl_t;

endpackage

FILE: hdl/sorted_static_list_insert.sv
// Top level of the sorted static list: controller, row of slots, read tree.
// Uses ssli_pkg, ssli_cell, ssli_prefix and the assertion header.
//
// Usage:
//   Drive item and raise start; the item is taken at a rising edge where
//   start is high and busy is low. Commands: append at tail, insert at head,
//   ordered insert before the first entry whose key is not less than the new
//   key, and read at a position. Every item gives exactly one result.
//   The result sits on result for one cycle with done high; the receiver
//   must take it then, it cannot hold results off.
// Sequence:
//   Acceptance edge, then an evaluate cycle (each slot compares its key and
//   the read tree registers per-group picks), then an apply cycle (prefix OR
//   finds the insert point, the slots at and above it shift or load at once).
//   done is high in the cycle after apply, and a new item can be taken in the
//   same cycle done is high; no new item is taken before the last one's result.
// Reset:
//   rst_n clears the entry count and the controller; slot contents are not
//   cleared and are only read below the count. An insert into a full list
//   is rejected with accepted low and the list left as it was.
`include "sorted_static_list_insert_assert.svh"

module sorted_static_list_insert
    import ssli_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  item,
    output logic      busy,
    output logic      done,
    output out_item_t result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int NGRP  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    in_item_t         item_reg;
    in_item_t         item_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             done_next;
    out_item_t        result_reg;
    out_item_t        result_next;

    entry_t           group_reg [NGRP];
    entry_t           group_next [NGRP];
    entry_t           read_or;

    cell_ctl_t        ctl;
    entry_t           cell_q  [CAPACITY];
    entry_t           cell_rd [CAPACITY];
    logic [CAPACITY-1:0] stop;
    logic [CAPACITY-1:0] pre;

    logic is_ins;
    logic full;
    logic pos_ok;
    logic ins_ok;

    assign is_ins = item_reg.cmd != CMD_READ;
    assign full   = count_reg == CAP_C;
    assign pos_ok = (32'(item_reg.position) < 32'(count_reg))
                    && (32'(item_reg.position) < 32'(CAPACITY));
    assign ins_ok = is_ins && !full;

    assign ctl.eval  = state_reg == S_EVAL;
    assign ctl.write = (state_reg == S_APPLY) && ins_ok;
    assign ctl.item  = item_reg;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            ssli_cell #(
                .IDX   (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .count      (count_reg),
                .pre_here   (pre[i]),
                .pre_prev   (1'b0),
                .prev_entry ('0),
                .entry      (cell_q[i]),
                .stop       (stop[i]),
                .rd         (cell_rd[i])
            );
        end
        else
        begin : g_rest
            ssli_cell #(
                .IDX   (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .count      (count_reg),
                .pre_here   (pre[i]),
                .pre_prev   (pre[i-1]),
                .prev_entry (cell_q[i-1]),
                .entry      (cell_q[i]),
                .stop       (stop[i]),
                .rd         (cell_rd[i])
            );
        end
    end

    ssli_prefix #(
        .N (CAPACITY)
    ) u_prefix (
        .stop (stop),
        .pre  (pre)
    );

    // first level of the read tree: one OR per group of slots, registered
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (g * GROUP_SIZE + k < CAPACITY)
                begin
                    group_next[g] = group_next[g] | cell_rd[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg <= group_next;
    end

    always_comb
    begin
        read_or = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            read_or = read_or | group_reg[g];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                count_next               = ins_ok ? count_reg + 1'b1 : count_reg;
                done_next                = 1'b1;
                result_next.accepted     = is_ins ? !full : pos_ok;
                result_next.count        = 8'(count_next);
                result_next.full_res     = count_next == CAP_C;
                result_next.empty_res    = count_next == '0;
                result_next.read_key     = (!is_ins && pos_ok) ? read_or.key : '0;
                result_next.read_payload = (!is_ins && pos_ok) ? read_or.payload : '0;
                state_next               = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            item_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            item_reg   <= item_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    `SSLI_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CAP_C, "entry count above capacity")
    `SSLI_ASSERT_NEXT(a_done_after_apply, state_reg == S_APPLY, done_reg, "no result after apply")
    `SSLI_ASSERT_NEXT(a_count_hold, state_reg != S_APPLY, $stable(count_reg), "count moved outside apply")
    `SSLI_ASSERT_IMPL(a_reject_zero, done_reg && !result_reg.accepted, (result_reg.read_key == '0) && (result_reg.read_payload == '0), "rejected item carries read data")

endmodule

FILE: hdl/ssli_cell.sv
// One list slot: holds an entry, decides whether the insert point is here or
// below, and shifts from its lower neighbor. Uses ssli_pkg.
module ssli_cell
    import ssli_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctl_t        ctl,
    input  logic [CNT_W-1:0] count,
    input  logic             pre_here,
    input  logic             pre_prev,
    input  entry_t           prev_entry,
    output entry_t           entry,
    output logic             stop,
    output entry_t           rd
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    entry_t entry_reg;
    logic   stop_reg;
    logic   stop_next;
    logic   valid;
    logic   less;
    logic   sel;

    assign valid = IDX_C < count;
    assign less  = $signed(entry_reg.key) < $signed(ctl.item.key);
    assign sel   = valid && (32'(ctl.item.position) == 32'(IDX));

    always_comb
    begin
        unique case (ctl.item.cmd)
            CMD_APPEND:  stop_next = !valid;
            CMD_HEAD:    stop_next = 1'b1;
            CMD_ORDERED: stop_next = !(valid && less);
            default:     stop_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg <= 1'b0;
        end
        else if (ctl.eval)
        begin
            stop_reg <= stop_next;
        end
    end

    // slots above the insert point take the lower neighbor's entry
    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            if (pre_prev)
            begin
                entry_reg <= prev_entry;
            end
            else if (pre_here)
            begin
                entry_reg <= '{key: ctl.item.key, payload: ctl.item.payload};
            end
        end
    end

    assign entry = entry_reg;
    assign stop  = stop_reg;
    assign rd    = sel ? entry_reg : '0;

endmodule

FILE: hdl/ssli_prefix.sv
// Log-depth prefix OR over the cells' stop flags: bit i is set when some
// slot at or below i is the insert point. Uses ssli_pkg.
module ssli_prefix
    import ssli_pkg::*;
#(
    parameter int N = CAPACITY_DEF
)
(
    input  logic [N-1:0] stop,
    output logic [N-1:0] pre
);

    localparam int LV = $clog2(N);

    logic [N-1:0] lvl [0:LV];

    assign lvl[0] = stop;

    for (genvar l = 0; l < LV; l++)
    begin : g_lvl
        for (genvar i = 0; i < N; i++)
        begin : g_bit
            if (i >= (1 << l))
            begin : g_or
                assign lvl[l+1][i] = lvl[l][i] | lvl[l][i - (1 << l)];
            end
            else
            begin : g_pass
                assign lvl[l+1][i] = lvl[l][i];
            end
        end
    end

    assign pre = lvl[LV];

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for sorted_static_list_insert: directed and random
// commands, a queue-fed driver, a strobe monitor and an in-bench list predictor.
// Depends on ssli_pkg and the sorted_static_list_insert RTL.
module tb_top;
    import ssli_pkg::*;

    localparam int LIST_CAP = CAPACITY_DEF;

    typedef struct {
        in_item_t cmd_item;
        bit       drain_first;   // hold this item until every result is back
    } queued_cmd_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_item_t  item = '0;
    logic      busy;
    logic      done;
    out_item_t result;

    queued_cmd_t cmd_queue[$];
    out_item_t   results_due[$];

    // predictor copy of the list
    logic signed [31:0] list_keys[LIST_CAP];
    logic [63:0]        list_payloads[LIST_CAP];
    int                 list_count = 0;

    int err_count = 0;
    int burst_left = 0;
    int gap_left = 0;

    sorted_static_list_insert #(.CAPACITY(LIST_CAP)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #10 clk = ~clk;

    // update the list copy for one command and queue the result it must give
    task automatic apply_list_command(input in_item_t it);
        out_item_t r;
        int        at;
        r = '0;
        if (it.cmd == CMD_READ) begin
            if (it.position < list_count) begin
                r.accepted     = 1'b1;
                r.read_key     = list_keys[it.position];
                r.read_payload = list_payloads[it.position];
            end
        end
        else if (list_count < LIST_CAP) begin
            case (it.cmd)
                CMD_APPEND: at = list_count;
                CMD_HEAD:   at = 0;
                default:
                begin
                    at = 0;
                    while (at < list_count && list_keys[at] < it.key)
                        at++;
                end
            endcase
            for (int k = list_count; k > at; k--)
            begin
                list_keys[k]     = list_keys[k - 1];
                list_payloads[k] = list_payloads[k - 1];
            end
            list_keys[at]     = it.key;
            list_payloads[at] = it.payload;
            list_count++;
            r.accepted = 1'b1;
        end
        r.count     = list_count[7:0];
        r.full_res  = (list_count == LIST_CAP);
        r.empty_res = (list_count == 0);
        results_due.push_back(r);
    endtask

    task automatic queue_cmd(input cmd_t c, input logic signed [31:0] k,
                             input logic [63:0] p, input logic [6:0] pos,
                             input bit drain);
        queued_cmd_t q;
        q.cmd_item.cmd      = c;
        q.cmd_item.key      = k;
        q.cmd_item.payload  = p;
        q.cmd_item.position = pos;
        q.drain_first       = drain;
        cmd_queue.push_back(q);
    endtask

    // half the keys from a narrow band so equal keys meet often
    function automatic logic signed [31:0] pick_key();
        if ($urandom_range(0, 1) == 0)
            return $urandom;
        return $signed($urandom_range(0, 15)) - 8;
    endfunction

    function automatic logic [63:0] pick_payload();
        return {$urandom, $urandom};
    endfunction

    // driver: item taken at an edge with start high and busy low
    always @(posedge clk)
    begin
        queued_cmd_t nxt;
        if (rst_n) begin
            if (start && !busy)
                apply_list_command(item);
            if (start && busy) begin
                // hold the item until it is taken
            end
            else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end
            else if (cmd_queue.size() == 0 ||
                     (cmd_queue[0].drain_first && results_due.size() != 0)) begin
                start <= 1'b0;
            end
            else begin
                nxt = cmd_queue.pop_front();
                item  <= nxt.cmd_item;
                start <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else begin
                    burst_left--;
                end
            end
        end
    end

    // monitor: sample mid-cycle so the check never races the driver
    always @(negedge clk)
    begin
        out_item_t want;
        if (rst_n && done) begin
            if (results_due.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result: %p", result);
            end
            else begin
                want = results_due.pop_front();
                if (result !== want) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("mismatch: expected acc=%0b cnt=%0d full=%0b empty=%0b %s",
                                 want.accepted, want.count, want.full_res,
                                 want.empty_res, "");
                        $display("  expected key=%0d pay=%h",
                                 want.read_key, want.read_payload);
                        $display("  got acc=%0b cnt=%0d full=%0b empty=%0b key=%0d pay=%h",
                                 result.accepted, result.count, result.full_res,
                                 result.empty_res, result.read_key, result.read_payload);
                    end
                end
            end
        end
    end

    initial
    begin
        cmd_t c;
        // empty list: reads rejected, first- and last-slot reads
        queue_cmd(CMD_READ, 0, 0, 7'd0, 1'b0);
        queue_cmd(CMD_READ, 0, 0, 7'd127, 1'b0);
        // ordered insert into empty list, then head/tail extremes
        queue_cmd(CMD_ORDERED, 0, 64'h1111_0000_0000_0001, 7'd5, 1'b0);
        queue_cmd(CMD_APPEND, 32'sh7FFF_FFFF, '1, 7'd127, 1'b0);
        queue_cmd(CMD_HEAD, 32'sh8000_0000, '0, 7'd0, 1'b0);
        // equal keys go before the existing one
        queue_cmd(CMD_ORDERED, 0, 64'h2222_0000_0000_0002, 7'd0, 1'b0);
        queue_cmd(CMD_ORDERED, -1, 64'h3333_0000_0000_0003, 7'd0, 1'b0);
        queue_cmd(CMD_ORDERED, 32'sh7FFF_FFFF, 64'h4444_0000_0000_0004, 7'd0, 1'b0);
        queue_cmd(CMD_ORDERED, 32'sh8000_0000, 64'h5555_0000_0000_0005, 7'd0, 1'b0);
        queue_cmd(CMD_ORDERED, 5, 64'hAAAA_5555_AAAA_5555, 7'd0, 1'b0);
        for (int p = 0; p <= 9; p++)
            queue_cmd(CMD_READ, 0, 0, p[6:0], 1'b0);
        // read exactly at the count
        queue_cmd(CMD_READ, 0, 0, 7'd8, 1'b0);

        // fill phase, weighted to ordered inserts
        for (int n = 0; n < 300; n++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2:       c = CMD_APPEND;
                3, 4, 5:       c = CMD_HEAD;
                6, 7, 8, 9, 10, 11, 12, 13, 14: c = CMD_ORDERED;
                default:       c = CMD_READ;
            endcase
            queue_cmd(c, pick_key(), pick_payload(),
                      ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                  : 7'($urandom_range(0, 15)),
                      1'b0);
        end

        // wait for a full drain once, then mostly reads on the full list
        queue_cmd(CMD_READ, 0, 0, 7'd127, 1'b1);
        for (int n = 0; n < 1180; n++)
        begin
            c = ($urandom_range(0, 3) == 0) ? cmd_t'($urandom_range(0, 2)) : CMD_READ;
            queue_cmd(c, $urandom, pick_payload(), 7'($urandom_range(0, 127)), 1'b0);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || start || results_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ssli_pkg.sv
hdl/ssli_cell.sv
hdl/ssli_prefix.sv
hdl/sorted_static_list_insert.sv
tb/tb_top.sv
